[rtl/ipd_pkg.sv]
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types and constants for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package ipd_pkg;

    localparam int LEN_W   = 17;
    localparam int DROP_W  = 32;
    localparam int SPACE_W = 16;
    localparam int PREFIX_LEN = 5;

    localparam logic [1:0] KIND_RX          = 2'd0;
    localparam logic [1:0] KIND_RESET       = 2'd1;
    localparam logic [1:0] KIND_TAKE_FAULT  = 2'd2;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 17'd512;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         rx_byte;
        logic               byte_valid;
        logic               overrun;
        logic [SPACE_W-1:0] sink_space;
    } in_t;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              is_payload;
        logic              to_reply;
        logic [LEN_W-1:0]  payload_offset;
        logic              frame_committed;
        logic              frame_dropped;
        logic [LEN_W-1:0]  payload_length;
        logic              fault_pending;
        logic [DROP_W-1:0] drop_total;
    } out_t;

    // Expected character of the "+IPD," prefix at a given position.
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = CHAR_PLUS;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h44;
            3'd4:    c = 8'h2C;
            default: c = CHAR_PLUS;
        endcase
        return c;
    endfunction

endpackage

[rtl/ipd_length_prefixed_deframer_unit.sv]
// ----------------------------------------------------------------------------
// ipd_length_prefixed_deframer_unit
// Receive-side deframer: finds "+IPD,<len>:" headers in a modem byte stream,
// flags payload bytes, and reports commits, drops and faults per beat.
// Rate: one beat is accepted every cycle unless the output stalls; each beat
// is registered in the input register, passes through the parser logic and
// is registered in the result register. A beat waits in the input register
// only while the result register holds a stalled beat.
// The max_payload register is written through cfg_write_en/cfg_write_data
// and should be changed only while no beats are in flight.
// ----------------------------------------------------------------------------
module ipd_length_prefixed_deframer_unit #(
    parameter int MAX_LENGTH_DIGITS = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  ipd_pkg::in_t                 in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output ipd_pkg::out_t                out_data,
    input  logic                         cfg_write_en,
    input  logic [ipd_pkg::LEN_W-1:0]    cfg_write_data
);
    import ipd_pkg::*;

    localparam int DCW = $clog2(MAX_LENGTH_DIGITS + 1);
    localparam logic [DCW-1:0] MAX_DIGITS = DCW'(MAX_LENGTH_DIGITS);

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_LEN     = 2'd1;
    localparam logic [1:0] PH_DATA    = 2'd2;
    localparam logic [1:0] PH_DISCARD = 2'd3;

    // Pipeline registers
    logic              in_valid_reg;
    in_t               in_data_reg;
    logic              out_valid_reg;
    out_t              out_data_reg;
    out_t              out_data_next;
    logic              advance;

    // Parser and status state
    logic [1:0]        phase_reg,       phase_next;
    logic [2:0]        prefix_pos_reg,  prefix_pos_next;
    logic [DCW-1:0]    digit_count_reg, digit_count_next;
    logic [LEN_W-1:0]  frame_length_reg, frame_length_next;
    logic [LEN_W-1:0]  payload_pos_reg, payload_pos_next;
    logic              restart_reg,     restart_next;
    logic              fault_reg,       fault_next;
    logic [DROP_W-1:0] drop_reg,        drop_next;
    logic [LEN_W-1:0]  max_payload_reg;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        logic              restart_eff;
        logic [1:0]        ph;
        logic [2:0]        ppos;
        logic [DCW-1:0]    dcnt;
        logic [LEN_W-1:0]  flen;
        logic [LEN_W-1:0]  ppl;
        logic [LEN_W-1:0]  ppl_inc;
        logic [7:0]        b;
        logic              is_digit;
        logic              drop_inc;

        b           = in_data_reg.rx_byte;
        restart_eff = restart_reg ||
                      (in_data_reg.kind == KIND_RX && in_data_reg.overrun);
        // A pending restart presents a fresh parser to the incoming byte.
        ph   = restart_eff ? PH_HUNT : phase_reg;
        ppos = restart_eff ? 3'd0 : prefix_pos_reg;
        dcnt = restart_eff ? '0 : digit_count_reg;
        flen = restart_eff ? '0 : frame_length_reg;
        ppl  = restart_eff ? '0 : payload_pos_reg;
        ppl_inc  = ppl + LEN_W'(1);
        is_digit = (b >= CHAR_0) && (b <= CHAR_9);
        drop_inc = 1'b0;

        phase_next        = phase_reg;
        prefix_pos_next   = prefix_pos_reg;
        digit_count_next  = digit_count_reg;
        frame_length_next = frame_length_reg;
        payload_pos_next  = payload_pos_reg;
        restart_next      = restart_reg;
        fault_next        = fault_reg;

        out_data_next = '0;

        case (in_data_reg.kind)
            KIND_RX:
            begin
                if (in_data_reg.overrun)
                begin
                    drop_inc     = 1'b1;
                    fault_next   = 1'b1;
                    restart_next = 1'b1;
                end
                if (in_data_reg.byte_valid)
                begin
                    restart_next      = 1'b0;
                    phase_next        = ph;
                    prefix_pos_next   = ppos;
                    digit_count_next  = dcnt;
                    frame_length_next = flen;
                    payload_pos_next  = ppl;
                    out_data_next.out_byte = b;
                    case (ph)
                        PH_HUNT:
                        begin
                            if (b == prefix_char(ppos))
                            begin
                                if (ppos == 3'(PREFIX_LEN - 1))
                                begin
                                    phase_next      = PH_LEN;
                                    prefix_pos_next = 3'd0;
                                end
                                else
                                begin
                                    prefix_pos_next = ppos + 3'd1;
                                end
                            end
                            else
                            begin
                                prefix_pos_next = (b == CHAR_PLUS) ? 3'd1 : 3'd0;
                            end
                        end
                        PH_LEN:
                        begin
                            if (is_digit && dcnt < MAX_DIGITS)
                            begin
                                frame_length_next = (flen << 3) + (flen << 1)
                                                  + {13'd0, b[3:0]};
                                digit_count_next  = dcnt + DCW'(1);
                            end
                            else if (b == CHAR_COLON && dcnt != '0 && flen != '0)
                            begin
                                payload_pos_next = '0;
                                if (flen <= max_payload_reg)
                                begin
                                    phase_next = PH_DATA;
                                end
                                else
                                begin
                                    phase_next = PH_DISCARD;
                                    drop_inc   = 1'b1;
                                end
                            end
                            else
                            begin
                                phase_next        = PH_HUNT;
                                digit_count_next  = '0;
                                frame_length_next = '0;
                                payload_pos_next  = '0;
                                prefix_pos_next   = (b == CHAR_PLUS) ? 3'd1 : 3'd0;
                            end
                        end
                        default:
                        begin
                            out_data_next.is_payload     = 1'b1;
                            out_data_next.payload_offset = ppl;
                            out_data_next.payload_length = flen;
                            payload_pos_next             = ppl_inc;
                            if (ppl_inc >= flen)
                            begin
                                if (ph == PH_DATA && flen <= {1'b0, in_data_reg.sink_space})
                                begin
                                    out_data_next.frame_committed = 1'b1;
                                end
                                else
                                begin
                                    // Oversize frames were counted at the colon.
                                    if (ph == PH_DATA)
                                    begin
                                        drop_inc = 1'b1;
                                    end
                                    fault_next                  = 1'b1;
                                    out_data_next.frame_dropped = 1'b1;
                                end
                                phase_next        = PH_HUNT;
                                prefix_pos_next   = 3'd0;
                                digit_count_next  = '0;
                                frame_length_next = '0;
                                payload_pos_next  = '0;
                            end
                        end
                    endcase
                    out_data_next.to_reply = !out_data_next.is_payload;
                end
                out_data_next.fault_pending = fault_next;
            end
            KIND_RESET:
            begin
                fault_next   = 1'b0;
                restart_next = 1'b1;
                out_data_next.fault_pending = 1'b0;
            end
            KIND_TAKE_FAULT:
            begin
                out_data_next.fault_pending = fault_reg;
                fault_next = 1'b0;
            end
            default:
            begin
                out_data_next.fault_pending = fault_reg;
            end
        endcase

        drop_next = drop_reg + DROP_W'(drop_inc);
        out_data_next.drop_total = drop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= PH_HUNT;
            prefix_pos_reg   <= 3'd0;
            digit_count_reg  <= '0;
            frame_length_reg <= '0;
            payload_pos_reg  <= '0;
            restart_reg      <= 1'b0;
            fault_reg        <= 1'b0;
            drop_reg         <= '0;
            max_payload_reg  <= MAX_PAYLOAD_RESET;
        end
        else
        begin
            if (cfg_write_en)
            begin
                max_payload_reg <= cfg_write_data;
            end
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (in_valid_reg && advance)
            begin
                phase_reg        <= phase_next;
                prefix_pos_reg   <= prefix_pos_next;
                digit_count_reg  <= digit_count_next;
                frame_length_reg <= frame_length_next;
                payload_pos_reg  <= payload_pos_next;
                restart_reg      <= restart_next;
                fault_reg        <= fault_next;
                drop_reg         <= drop_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
        if (in_valid_reg && advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

[rtl/ipd_checker.sv]
// ----------------------------------------------------------------------------
// ipd_checker
// Port-level checks on the deframer's result beats, bound to the deframer module.
// ----------------------------------------------------------------------------
module ipd_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_stall,
    input ipd_pkg::out_t out_data
);
    import ipd_pkg::*;

    // A result beat held by the sink stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    // A byte goes either to the payload path or to the reply stream.
    a_route: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.is_payload && out_data.to_reply))
        else $error("byte routed to both payload and reply");

    // Frame end outcomes occur only on payload bytes and are exclusive.
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.frame_committed || out_data.frame_dropped) |->
        out_data.is_payload && !(out_data.frame_committed && out_data.frame_dropped))
        else $error("bad frame end outcome");

    // Payload offsets stay inside the declared length.
    a_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_payload |->
        out_data.payload_offset < out_data.payload_length)
        else $error("payload offset beyond frame length");

endmodule

bind ipd_length_prefixed_deframer_unit ipd_checker u_ipd_checker (.*);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the +IPD length-prefixed deframer. A predictor
// tracks the parser, fault flag and drop counter beat by beat; every result
// beat is compared field by field against it. Directed frames and special
// cases come first, then random well-formed and broken frames under several
// max_payload settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import ipd_pkg::*;

    localparam int DIGIT_LIMIT    = 5;
    localparam int MAX_DECLARED   = 99999;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 100;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [0:4][7:0] IPD_MARK = {CHAR_PLUS, "I", "P", "D", ","};

    typedef enum logic [1:0] {
        HUNT_PREFIX,
        READ_LENGTH,
        TAKE_PAYLOAD,
        SKIP_PAYLOAD
    } parse_phase_e;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    in_t               in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    out_t              out_data;
    logic              cfg_write_en = 1'b0;
    logic [LEN_W-1:0]  cfg_write_data = '0;

    // Predictor state.
    parse_phase_e      phase;
    logic [2:0]        match_pos;
    logic [2:0]        digits_seen;
    logic [LEN_W-1:0]  frame_len;
    logic [LEN_W-1:0]  byte_pos;
    logic              restart_due;
    logic              fault_latched;
    logic [DROP_W-1:0] drop_count;
    logic [LEN_W-1:0]  max_payload_cfg;

    out_t              expected_q[$];
    out_t              got_beat;
    out_t              want_beat;

    logic              quiet = 1'b0;
    logic              noisy = 1'b0;
    int unsigned       stall_left = 0;
    int unsigned       idle_cycles = 0;
    int unsigned       mismatches = 0;
    int unsigned       beats_in = 0;
    int unsigned       results_checked = 0;
    int unsigned       commits_seen = 0;
    int unsigned       drops_seen = 0;
    int unsigned       bytes_sent = 0;

    always #5 clk = ~clk;

    ipd_length_prefixed_deframer_unit #(
        .MAX_LENGTH_DIGITS(DIGIT_LIMIT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void clear_frame_state();
        phase       = HUNT_PREFIX;
        match_pos   = '0;
        digits_seen = '0;
        frame_len   = '0;
        byte_pos    = '0;
    endfunction

    function automatic void reset_predictor();
        clear_frame_state();
        restart_due     = 1'b0;
        fault_latched   = 1'b0;
        drop_count      = '0;
        max_payload_cfg = MAX_PAYLOAD_RESET;
    endfunction

    function automatic out_t deframe_predict(input in_t beat);
        out_t        r;
        logic [7:0]  b;
        int unsigned len_calc;
        r = '0;
        b = beat.rx_byte;
        case (beat.kind)
            KIND_RX:
            begin
                if (beat.overrun)
                begin
                    drop_count    = drop_count + 1'b1;
                    fault_latched = 1'b1;
                    restart_due   = 1'b1;
                end
                if (beat.byte_valid)
                begin
                    if (restart_due)
                    begin
                        clear_frame_state();
                        restart_due = 1'b0;
                    end
                    r.out_byte = b;
                    case (phase)
                        HUNT_PREFIX:
                        begin
                            if (b == IPD_MARK[(match_pos < PREFIX_LEN) ? match_pos : 3'd0])
                            begin
                                match_pos = match_pos + 1'b1;
                                if (match_pos >= PREFIX_LEN)
                                begin
                                    clear_frame_state();
                                    phase = READ_LENGTH;
                                end
                            end
                            else
                                match_pos = (b == CHAR_PLUS) ? 3'd1 : 3'd0;
                        end
                        READ_LENGTH:
                        begin
                            if (b >= CHAR_0 && b <= CHAR_9 && digits_seen < DIGIT_LIMIT)
                            begin
                                len_calc    = frame_len * 10 + (b - CHAR_0);
                                frame_len   = LEN_W'(len_calc);
                                digits_seen = digits_seen + 1'b1;
                            end
                            else if (b == CHAR_COLON && digits_seen != 0 && frame_len != 0)
                            begin
                                byte_pos = '0;
                                if (frame_len <= max_payload_cfg)
                                    phase = TAKE_PAYLOAD;
                                else
                                begin
                                    phase      = SKIP_PAYLOAD;
                                    drop_count = drop_count + 1'b1;
                                end
                            end
                            else
                            begin
                                // A '+' that breaks a header may open the next one.
                                clear_frame_state();
                                match_pos = (b == CHAR_PLUS) ? 3'd1 : 3'd0;
                            end
                        end
                        default:
                        begin
                            r.is_payload     = 1'b1;
                            r.payload_offset = byte_pos;
                            r.payload_length = frame_len;
                            byte_pos = byte_pos + 1'b1;
                            if (byte_pos >= frame_len)
                            begin
                                if (phase == TAKE_PAYLOAD && frame_len <= beat.sink_space)
                                    r.frame_committed = 1'b1;
                                else
                                begin
                                    // Oversize frames were already counted at the colon.
                                    if (phase == TAKE_PAYLOAD)
                                        drop_count = drop_count + 1'b1;
                                    fault_latched   = 1'b1;
                                    r.frame_dropped = 1'b1;
                                end
                                clear_frame_state();
                            end
                        end
                    endcase
                    r.to_reply = !r.is_payload;
                end
                r.fault_pending = fault_latched;
            end
            KIND_RESET:
            begin
                fault_latched   = 1'b0;
                restart_due     = 1'b1;
                r.fault_pending = 1'b0;
            end
            KIND_TAKE_FAULT:
            begin
                r.fault_pending = fault_latched;
                fault_latched   = 1'b0;
            end
            default:
                r.fault_pending = fault_latched;
        endcase
        r.drop_total = drop_count;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        // Keep the log readable when a design is badly broken.
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results_checked, name, got, want));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            expected_q.push_back(deframe_predict(in_data));
            beats_in++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            got_beat = out_data;
            if (expected_q.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_checked));
            else
            begin
                want_beat = expected_q.pop_front();
                check_field("out_byte", got_beat.out_byte, want_beat.out_byte);
                check_field("is_payload", got_beat.is_payload, want_beat.is_payload);
                check_field("to_reply", got_beat.to_reply, want_beat.to_reply);
                check_field("payload_offset", got_beat.payload_offset,
                            want_beat.payload_offset);
                check_field("frame_committed", got_beat.frame_committed,
                            want_beat.frame_committed);
                check_field("frame_dropped", got_beat.frame_dropped,
                            want_beat.frame_dropped);
                check_field("payload_length", got_beat.payload_length,
                            want_beat.payload_length);
                check_field("fault_pending", got_beat.fault_pending,
                            want_beat.fault_pending);
                check_field("drop_total", got_beat.drop_total, want_beat.drop_total);
            end
            if (got_beat.frame_committed)
                commits_seen++;
            if (got_beat.frame_dropped)
                drops_seen++;
            stall_left = quiet ? 0 : $urandom_range(0, 4);
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no handshake for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic in_t make_rx(input logic [7:0] b, input logic [SPACE_W-1:0] space,
                                    input logic ovr, input logic vld);
        in_t beat;
        beat.kind       = KIND_RX;
        beat.rx_byte    = b;
        beat.byte_valid = vld;
        beat.overrun    = ovr;
        beat.sink_space = space;
        return beat;
    endfunction

    // Leaves valid high after acceptance so back-to-back beats need no toggle.
    task automatic send_beat(input in_t beat);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_rx(input logic [7:0] b, input logic [SPACE_W-1:0] space);
        if (noisy && $urandom_range(0, 9) == 0)
            send_beat(make_rx(8'($urandom), 16'($urandom), 1'b0, 1'b0));
        send_beat(make_rx(b, space, 1'b0, 1'b1));
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic [SPACE_W-1:0] space);
        int i;
        for (i = 0; i < s.len(); i++)
            send_rx(s[i], space);
    endtask

    task automatic send_ctrl(input logic [1:0] kind);
        in_t beat;
        beat.kind       = kind;
        beat.rx_byte    = 8'($urandom);
        beat.byte_valid = 1'($urandom);
        beat.overrun    = 1'($urandom);
        beat.sink_space = 16'($urandom);
        send_beat(beat);
    endtask

    task automatic abort_frame();
        if ($urandom_range(0, 1) == 0)
            send_ctrl(KIND_RESET);
        else
            send_beat(make_rx(8'($urandom), 16'($urandom), 1'b1, 1'b0));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_max_payload(input logic [LEN_W-1:0] value);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en    <= 1'b0;
        max_payload_cfg  = value;
    endtask

    task automatic send_random_frame();
        int unsigned        pick;
        int unsigned        len;
        int unsigned        want_space;
        int unsigned        cut;
        int unsigned        i;
        logic [7:0]         b;
        logic [SPACE_W-1:0] space;
        string              digits;
        noisy = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(0, 2)) send_rx(8'($urandom), 16'($urandom));

        pick = $urandom_range(0, 99);
        if (pick < 75)
            len = $urandom_range(1, 8);
        else if (pick < 85)
            len = $urandom_range(9, 40);
        else if (pick < 95)
        begin
            len = max_payload_cfg + $urandom_range(0, 2);
            len = (len > 1) ? len - 1 : 1;
            if (len > MAX_DECLARED)
                len = MAX_DECLARED;
        end
        else
            len = $urandom_range(0, 1) ? MAX_DECLARED : $urandom_range(1000, MAX_DECLARED);

        digits = $sformatf("%0d", len);
        while (digits.len() < DIGIT_LIMIT && $urandom_range(0, 3) == 0)
            digits = {"0", digits};

        case ($urandom_range(0, 4))
            0:       want_space = len;
            1:       want_space = len - 1;
            2:       want_space = $urandom_range(0, 65535);
            3:       want_space = 65535;
            default: want_space = len + $urandom_range(1, 3);
        endcase
        space = (want_space > 65535) ? 16'hFFFF : 16'(want_space);

        send_text("+IPD,", 16'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 72)
        begin
            send_text({digits, ":"}, 16'($urandom));
            // Huge declared lengths are cut short by a restart.
            cut = (len > 300) ? $urandom_range(1, 4) : len;
            for (i = 0; i < cut; i++)
                send_rx(8'($urandom), (i == len - 1) ? space : 16'($urandom));
            if (cut < len)
                abort_frame();
        end
        else if (pick < 76)
            send_rx(CHAR_COLON, 16'($urandom));
        else if (pick < 80)
        begin
            digits = "0";
            repeat ($urandom_range(0, 4)) digits = {digits, "0"};
            send_text({digits, ":"}, 16'($urandom));
        end
        else if (pick < 84)
            send_text({$sformatf("%0d", $urandom_range(100000, 999999)), ":"},
                      16'($urandom));
        else if (pick < 88)
        begin
            send_text(digits, 16'($urandom));
            do
                b = 8'($urandom);
            while ((b >= CHAR_0 && b <= CHAR_9) || b == CHAR_COLON);
            send_rx(b, 16'($urandom));
        end
        else if (pick < 92)
        begin
            send_text({digits, "+IPD,1:"}, 16'($urandom));
            send_rx(8'($urandom), 16'hFFFF);
        end
        else if (pick < 96)
        begin
            send_text({digits, ":"}, 16'($urandom));
            cut = $urandom_range(0, (len > 4) ? 3 : len - 1);
            for (i = 0; i < cut; i++)
                send_rx(8'($urandom), 16'($urandom));
            abort_frame();
        end
        else
        begin
            // Overrun arriving with a '+' restarts the parser on that very byte.
            send_text(digits, 16'($urandom));
            send_beat(make_rx(CHAR_PLUS, 16'($urandom), 1'b1, 1'b1));
            send_text("IPD,1:", 16'($urandom));
            send_rx(8'($urandom), 16'hFFFF);
        end

        pick = $urandom_range(0, 19);
        if (pick < 2)
            send_ctrl(KIND_TAKE_FAULT);
        else if (pick == 2)
            send_ctrl(KIND_RESET);
        else if (pick == 3)
            send_ctrl(KIND_UNUSED);
    endtask

    task automatic run_random_stream(input int unsigned n_bytes);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            send_random_frame();
            if ($urandom_range(0, 39) == 0)
                wait_idle();
        end
        noisy = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_cases();
        send_text("+IPD,2:", 16'hFFFF);
        send_rx(8'h00, 16'hFFFF);
        send_rx(8'hFF, 16'h0002);
        // Sink too small for the frame: dropped and fault raised.
        send_text("+IPD,1:", 16'h0000);
        send_rx(8'h5A, 16'h0000);
        send_ctrl(KIND_TAKE_FAULT);
        send_ctrl(KIND_UNUSED);
        send_beat(make_rx(8'hA5, 16'h1234, 1'b1, 1'b0));
        send_ctrl(KIND_RESET);
        send_beat(make_rx(8'hFF, 16'hFFFF, 1'b0, 1'b0));
    endtask

    task automatic test_default_limit_stream();
        run_random_stream(70);
    endtask

    task automatic test_smallest_limit();
        write_max_payload(17'd1);
        send_text("+IPD,1:", 16'h0001);
        send_rx(8'h61, 16'h0001);
        send_text("+IPD,2:", 16'hFFFF);
        send_rx(8'h62, 16'hFFFF);
        send_rx(8'h63, 16'hFFFF);
        run_random_stream(30);
    endtask

    task automatic test_largest_limit();
        int i;
        write_max_payload(17'(MAX_DECLARED));
        send_text("+IPD,260:", 16'($urandom));
        for (i = 0; i < 260; i++)
            send_rx(8'($urandom), (i == 259) ? 16'd260 : 16'($urandom));
        send_text("+IPD,99999:", 16'hFFFF);
        send_rx(8'($urandom), 16'hFFFF);
        send_rx(8'($urandom), 16'hFFFF);
        send_ctrl(KIND_RESET);
        quiet = 1'b1;
        run_random_stream(25);
        wait_idle();
        quiet = 1'b0;
        run_random_stream(25);
    endtask

    task automatic test_tight_limit();
        write_max_payload(17'd6);
        run_random_stream(25);
        wait_idle();
        run_random_stream(25);
    endtask

    initial
    begin
        reset_predictor();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_default_limit_stream();
        test_smallest_limit();
        test_largest_limit();
        test_tight_limit();

        wait_idle();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_q.size()));

        $display("Sent %0d beats (%0d bytes) and checked %0d results:",
                 beats_in, bytes_sent, results_checked);
        $display("%0d frames committed, %0d dropped; max_payload 512, 1, 99999 and 6.",
                 commits_seen, drops_seen);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
